@@ rtl/classless_route_option_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// classless route option decoder assertion macros
// shared property shapes for the decoder modules
// ----------------------------------------------------------------------------
`ifndef CLASSLESS_ROUTE_OPTION_DECODER_DEFINES_SVH
`define CLASSLESS_ROUTE_OPTION_DECODER_DEFINES_SVH

// same-cycle implication
`define CROD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CROD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/crod_pkg.sv @@
// ----------------------------------------------------------------------------
// crod_pkg
// types and constants shared by the classless route option decoder
// ----------------------------------------------------------------------------
`default_nettype none

package crod_pkg;

    localparam int unsigned AddrW      = 32;
    localparam int unsigned ByteW      = 8;
    localparam int unsigned PrefixW    = 6;
    localparam int unsigned CountW     = 3;
    localparam int unsigned StatusW    = 2;
    localparam logic [7:0]  MaxPrefix  = 8'd32;
    localparam logic [2:0]  GwBytes    = 3'd4;

    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_DEST   = 2'd1,
        PH_GW     = 2'd2,
        PH_SKIP   = 2'd3
    } phase_t;

    typedef enum logic [StatusW-1:0] {
        ST_ROUTE   = 2'd0,
        ST_BAD_LEN = 2'd1,
        ST_TRUNC   = 2'd2
    } status_t;

    typedef struct packed {
        status_t             status;
        logic [AddrW-1:0]    dest;
        logic [PrefixW-1:0]  prefix;
        logic [AddrW-1:0]    gateway;
        logic                opt_end;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/crod_parser.sv @@
// ----------------------------------------------------------------------------
// crod_parser
// per-word entry parser: holds entry state and forms at most one result per word
// ----------------------------------------------------------------------------
`default_nettype none

`include "classless_route_option_decoder_defines.svh"

module crod_parser (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         step,
    input  wire logic [crod_pkg::ByteW-1:0]   data_byte,
    input  wire logic                         last_byte,
    output logic                              res_valid,
    output crod_pkg::result_t                 res
);

    crod_pkg::phase_t                 phase_reg, phase_next;
    logic [crod_pkg::PrefixW-1:0]     prefix_len_reg, prefix_len_next;
    logic [crod_pkg::CountW-1:0]      bytes_left_reg, bytes_left_next;
    logic [crod_pkg::AddrW-1:0]       dest_reg, dest_next;
    logic [crod_pkg::AddrW-1:0]       gw_reg, gw_next;

    logic                             bad_len;
    logic [crod_pkg::CountW-1:0]      new_count;
    logic [crod_pkg::CountW-1:0]      total;
    logic [crod_pkg::CountW-1:0]      left_dec;
    logic [1:0]                       idx;
    logic [crod_pkg::AddrW-1:0]       placed;
    logic [crod_pkg::AddrW-1:0]       gw_shift;
    logic [crod_pkg::PrefixW-1:0]     p_clamp;
    logic [crod_pkg::AddrW-1:0]       mask;

    assign bad_len   = data_byte > crod_pkg::MaxPrefix;
    assign new_count = data_byte[5:3] + crod_pkg::CountW'(|data_byte[2:0]);
    assign total     = prefix_len_reg[5:3] + crod_pkg::CountW'(|prefix_len_reg[2:0]);
    assign left_dec  = bytes_left_reg - 3'd1;
    assign idx       = 2'(total - bytes_left_reg);
    assign gw_shift  = {gw_reg[crod_pkg::AddrW-crod_pkg::ByteW-1:0], data_byte};
    assign p_clamp   = (prefix_len_reg > crod_pkg::PrefixW'(crod_pkg::MaxPrefix))
                     ? crod_pkg::PrefixW'(crod_pkg::MaxPrefix) : prefix_len_reg;
    assign mask      = ~({crod_pkg::AddrW{1'b1}} >> p_clamp);

    always_comb
    begin
        unique case (idx)
            2'd0:    placed = {data_byte, 24'd0};
            2'd1:    placed = {8'd0, data_byte, 16'd0};
            2'd2:    placed = {16'd0, data_byte, 8'd0};
            default: placed = {24'd0, data_byte};
        endcase
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            crod_pkg::PH_PREFIX:
            begin
                if (bad_len)
                    phase_next = crod_pkg::PH_SKIP;
                else if (new_count == 3'd0)
                    phase_next = crod_pkg::PH_GW;
                else
                    phase_next = crod_pkg::PH_DEST;
            end
            crod_pkg::PH_DEST:
            begin
                if (left_dec == 3'd0)
                    phase_next = crod_pkg::PH_GW;
            end
            crod_pkg::PH_GW:
            begin
                if (left_dec == 3'd0)
                    phase_next = crod_pkg::PH_PREFIX;
            end
            default: phase_next = crod_pkg::PH_SKIP;
        endcase
        if (last_byte)
            phase_next = crod_pkg::PH_PREFIX;
    end

    // datapath and result
    always_comb
    begin
        prefix_len_next = prefix_len_reg;
        bytes_left_next = bytes_left_reg;
        dest_next       = dest_reg;
        gw_next         = gw_reg;
        res_valid       = 1'b0;
        res.status      = crod_pkg::ST_TRUNC;
        res.dest        = '0;
        res.prefix      = '0;
        res.gateway     = '0;
        res.opt_end     = last_byte;
        unique case (phase_reg)
            crod_pkg::PH_PREFIX:
            begin
                if (bad_len)
                begin
                    res_valid  = 1'b1;
                    res.status = crod_pkg::ST_BAD_LEN;
                end
                else
                begin
                    prefix_len_next = data_byte[crod_pkg::PrefixW-1:0];
                    dest_next       = '0;
                    gw_next         = '0;
                    bytes_left_next = (new_count == 3'd0) ? crod_pkg::GwBytes : new_count;
                    res_valid       = last_byte;
                end
            end
            crod_pkg::PH_DEST:
            begin
                dest_next       = dest_reg | placed;
                bytes_left_next = (left_dec == 3'd0) ? crod_pkg::GwBytes : left_dec;
                res_valid       = last_byte;
            end
            crod_pkg::PH_GW:
            begin
                gw_next         = gw_shift;
                bytes_left_next = left_dec;
                if (left_dec == 3'd0)
                begin
                    res_valid       = 1'b1;
                    res.status      = crod_pkg::ST_ROUTE;
                    res.dest        = dest_reg & mask;
                    res.prefix      = p_clamp;
                    res.gateway     = gw_shift;
                    dest_next       = '0;
                    gw_next         = '0;
                    prefix_len_next = '0;
                end
                else
                begin
                    res_valid = last_byte;
                end
            end
            default: ;
        endcase
        if (last_byte)
        begin
            prefix_len_next = '0;
            bytes_left_next = '0;
            dest_next       = '0;
            gw_next         = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= crod_pkg::PH_PREFIX;
            prefix_len_reg <= '0;
            bytes_left_reg <= '0;
            dest_reg       <= '0;
            gw_reg         <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            prefix_len_reg <= prefix_len_next;
            bytes_left_reg <= bytes_left_next;
            dest_reg       <= dest_next;
            gw_reg         <= gw_next;
        end
    end

    `CROD_ASSERT_NOW(a_err_fields_zero,
        res_valid && (res.status != crod_pkg::ST_ROUTE),
        (res.dest == '0) && (res.prefix == '0) && (res.gateway == '0),
        "error result carries nonzero fields")
    `CROD_ASSERT_NEXT(a_last_clears,
        step && last_byte,
        (phase_reg == crod_pkg::PH_PREFIX) && (bytes_left_reg == '0),
        "state not cleared after last word")
    `CROD_ASSERT_NEXT(a_skip_holds,
        step && !last_byte && (phase_reg == crod_pkg::PH_SKIP),
        phase_reg == crod_pkg::PH_SKIP,
        "left skip phase before option end")
    `CROD_ASSERT_NOW(a_prefix_range,
        phase_reg != crod_pkg::PH_SKIP,
        prefix_len_reg <= crod_pkg::PrefixW'(crod_pkg::MaxPrefix),
        "held prefix length above limit")

endmodule

`default_nettype wire

@@ rtl/classless_route_option_decoder.sv @@
// ----------------------------------------------------------------------------
// classless_route_option_decoder
// decodes classless static route option bytes into routes and error words
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  input     in         in_valid / in_ready    data_byte, last_byte
//  output    out        out_valid / out_ready  status, dest_address, prefix_bits,
//                                              gateway_address, option_end
//
// one input word per cycle while in_ready is high; a result appears on
// the output in the cycle after the word that causes it is taken
// the entry parser and one output register set the rate
// in_ready is high while the output register is empty or being drained
// asynchronous reset returns the parser to expecting a prefix length byte
// ----------------------------------------------------------------------------
`default_nettype none

`include "classless_route_option_decoder_defines.svh"

module classless_route_option_decoder (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [crod_pkg::ByteW-1:0]     data_byte,
    input  wire logic                           last_byte,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [crod_pkg::StatusW-1:0]        status,
    output logic [crod_pkg::AddrW-1:0]          dest_address,
    output logic [crod_pkg::PrefixW-1:0]        prefix_bits,
    output logic [crod_pkg::AddrW-1:0]          gateway_address,
    output logic                                option_end
);

    logic               in_fire;
    logic               res_valid;
    crod_pkg::result_t  res;
    crod_pkg::result_t  out_reg;
    logic               out_valid_reg, out_valid_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    crod_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (in_fire),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (in_fire && res_valid)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (in_fire && res_valid)
            out_reg <= res;
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_reg.status;
    assign dest_address    = out_reg.dest;
    assign prefix_bits     = out_reg.prefix;
    assign gateway_address = out_reg.gateway;
    assign option_end      = out_reg.opt_end;

    `CROD_ASSERT_NOW(a_ready_when_empty,
        !out_valid_reg,
        in_ready,
        "input stalled with empty output register")
    `CROD_ASSERT_NEXT(a_result_loaded,
        in_fire && res_valid,
        out_valid_reg,
        "result word not presented")

endmodule

`default_nettype wire
